@@ src/efb_pkg.sv @@
package efb_pkg;

    typedef struct packed {
        logic       operation;
        logic [4:0] red_in;
        logic [5:0] green_in;
        logic [4:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [4:0] red_out;
        logic [5:0] green_out;
        logic [4:0] blue_out;
        logic       is_edge;
        logic       last_pixel;
    } result_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb8_t;

    typedef logic [11:0] acc_t;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_RADIUS    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    localparam int CfgWidth = 11;

    function automatic logic [7:0] exp5(input logic [4:0] v);
        exp5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        exp6 = {v, v[5:4]};
    endfunction

    function automatic logic [3:0] alpha_of(input logic [7:0] radius);
        logic [3:0] a;
        case (radius)
            8'd1:    a = 4'd14;
            8'd2:    a = 4'd10;
            8'd3:    a = 4'd8;
            8'd4:    a = 4'd6;
            8'd5:    a = 4'd5;
            8'd6:    a = 4'd5;
            8'd7:    a = 4'd4;
            8'd8:    a = 4'd3;
            8'd9:    a = 4'd3;
            8'd10:   a = 4'd3;
            8'd11:   a = 4'd3;
            8'd12:   a = 4'd2;
            8'd13:   a = 4'd2;
            8'd14:   a = 4'd2;
            8'd15:   a = 4'd2;
            8'd16:   a = 4'd2;
            8'd17:   a = 4'd2;
            default: a = 4'd1;
        endcase
        alpha_of = a;
    endfunction

endpackage

@@ src/exp_blur_cartoon_edge_filter_top.sv @@
// Cartoon filter over a frame store of MAX_WIDTH x MAX_HEIGHT RGB888 pixels.
// The first read after a load or geometry change runs the blur if the
// radius register is nonzero: four line passes and a 565 truncation pass,
// each pixel visit a read state then a write state, bound by the single
// read and write port of the frame store. Each read then fetches, for an
// interior pixel, its nine neighborhood pixels one at a time through the
// shared difference unit; a border pixel goes straight to output. The block
// takes no new transfer while busy.
module exp_blur_cartoon_edge_filter_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [efb_pkg::CfgWidth-1:0] cfg_data,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  efb_pkg::pixel_t            pixel,
    output logic                       result_valid,
    input  logic                       result_stall,
    output efb_pkg::result_t           result
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int WW    = $clog2(MAXD + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLUR_RD,
        S_BLUR_WR,
        S_FIN_RD,
        S_FIN_WR,
        S_EDGE_RD,
        S_EDGE_WR,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [8:0]           width_reg;
    logic [8:0]           height_reg;
    logic [7:0]           radius_reg;
    logic [10:0]          thresh_reg;
    logic [NW-1:0]        load_pos_reg;
    logic [AW-1:0]        read_pos_reg;
    logic [WW-1:0]        x_reg;
    logic [WW-1:0]        y_reg;
    logic                 blur_done_reg;
    logic [1:0]           pass_reg;
    logic [WW-1:0]        line_reg;
    logic [WW-1:0]        k_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        start_reg;
    logic [3:0]           alpha_reg;
    efb_pkg::acc_t        acc_reg [3];
    logic [3:0]           estep_reg;
    efb_pkg::rgb8_t       center_reg;
    efb_pkg::rgb8_t       hold_reg;
    logic [10:0]          g1_reg;
    logic [10:0]          g2_reg;
    logic                 border_reg;
    logic                 result_valid_reg;
    efb_pkg::result_t     result_reg;

    logic [WW-1:0]        w_eff;
    logic [WW-1:0]        h_eff;
    logic [NW-1:0]        n_pix;
    logic [AW-1:0]        w_a;
    logic [AW-1:0]        n_a;
    logic [WW-1:0]        count;
    logic [WW-1:0]        lines;
    logic [AW-1:0]        elem_step;
    logic                 elem_back;
    logic [AW-1:0]        line_step;
    logic [AW-1:0]        edge_addr;
    logic                 out_free;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    efb_pkg::rgb8_t       mem_wdata;
    logic [AW-1:0]        mem_raddr;
    efb_pkg::rgb8_t       mem_rdata;
    efb_pkg::rgb8_t       load_px;

    efb_pkg::acc_t        acc_next [3];
    efb_pkg::rgb8_t       blur_px;
    efb_pkg::rgb8_t       trunc_px;
    logic [9:0]           diff_sum;

    always_comb
    begin
        if (width_reg == 9'd0)
            w_eff = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == 9'd0)
            h_eff = WW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = WW'(MAX_HEIGHT);
        else
            h_eff = WW'(height_reg);
    end

    assign n_pix = NW'(w_eff) * NW'(h_eff);
    assign w_a   = AW'(w_eff);
    assign n_a   = AW'(n_pix);

    // pass order: down columns, right rows, up columns, left rows
    always_comb
    begin
        case (pass_reg)
            2'd0:
            begin
                count = h_eff; lines = w_eff;
                elem_step = w_a; elem_back = 1'b0; line_step = AW'(1);
            end
            2'd1:
            begin
                count = w_eff; lines = h_eff;
                elem_step = AW'(1); elem_back = 1'b0; line_step = w_a;
            end
            2'd2:
            begin
                count = h_eff; lines = w_eff;
                elem_step = w_a; elem_back = 1'b1; line_step = AW'(1);
            end
            default:
            begin
                count = w_eff; lines = h_eff;
                elem_step = AW'(1); elem_back = 1'b1; line_step = w_a;
            end
        endcase
    end

    always_comb
    begin
        case (estep_reg)
            4'd0:    edge_addr = read_pos_reg;
            4'd1:    edge_addr = read_pos_reg - AW'(1);
            4'd2:    edge_addr = read_pos_reg + AW'(1);
            4'd3:    edge_addr = read_pos_reg - w_a;
            4'd4:    edge_addr = read_pos_reg + w_a;
            4'd5:    edge_addr = read_pos_reg - w_a - AW'(1);
            4'd6:    edge_addr = read_pos_reg + w_a + AW'(1);
            4'd7:    edge_addr = read_pos_reg - w_a + AW'(1);
            default: edge_addr = read_pos_reg + w_a - AW'(1);
        endcase
    end

    assign load_px.r = efb_pkg::exp5(pixel.red_in);
    assign load_px.g = efb_pkg::exp6(pixel.green_in);
    assign load_px.b = efb_pkg::exp5(pixel.blue_in);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = blur_px;
        mem_raddr = addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                mem_waddr = load_pos_reg[AW-1:0];
                mem_wdata = load_px;
                mem_we    = pixel_valid && (pixel.operation == efb_pkg::OP_LOAD)
                            && (load_pos_reg < n_pix);
            end
            S_BLUR_WR: mem_we = (k_reg != '0);
            S_FIN_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = trunc_px;
            end
            S_EDGE_RD: mem_raddr = edge_addr;
            default:   mem_we = 1'b0;
        endcase
    end

    efb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    efb_alu u_alu (
        .px       (mem_rdata),
        .hold     (hold_reg),
        .acc      (acc_reg),
        .alpha    (alpha_reg),
        .acc_next (acc_next),
        .blur_px  (blur_px),
        .trunc_px (trunc_px),
        .diff_sum (diff_sum)
    );

    assign out_free     = !result_valid_reg || !result_stall;
    assign pixel_stall  = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            width_reg        <= 9'd256;
            height_reg       <= 9'd256;
            radius_reg       <= '0;
            thresh_reg       <= '0;
            load_pos_reg     <= '0;
            read_pos_reg     <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            blur_done_reg    <= 1'b0;
            pass_reg         <= '0;
            line_reg         <= '0;
            k_reg            <= '0;
            addr_reg         <= '0;
            start_reg        <= '0;
            estep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    efb_pkg::REG_WIDTH:     width_reg  <= cfg_data[8:0];
                    efb_pkg::REG_HEIGHT:    height_reg <= cfg_data[8:0];
                    efb_pkg::REG_RADIUS:    radius_reg <= cfg_data[7:0];
                    efb_pkg::REG_THRESHOLD: thresh_reg <= cfg_data;
                    default:                thresh_reg <= thresh_reg;
                endcase
                if (cfg_index == efb_pkg::REG_WIDTH || cfg_index == efb_pkg::REG_HEIGHT)
                begin
                    load_pos_reg  <= '0;
                    read_pos_reg  <= '0;
                    x_reg         <= '0;
                    y_reg         <= '0;
                    blur_done_reg <= 1'b0;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pixel_valid)
                    begin
                        if (pixel.operation == efb_pkg::OP_LOAD)
                        begin
                            if (load_pos_reg < n_pix)
                                load_pos_reg <= load_pos_reg + NW'(1);
                            read_pos_reg  <= '0;
                            x_reg         <= '0;
                            y_reg         <= '0;
                            blur_done_reg <= 1'b0;
                        end
                        else if (!blur_done_reg && radius_reg != 8'd0)
                        begin
                            alpha_reg <= efb_pkg::alpha_of(radius_reg);
                            pass_reg  <= '0;
                            line_reg  <= '0;
                            k_reg     <= '0;
                            addr_reg  <= '0;
                            start_reg <= '0;
                            state_reg <= S_BLUR_RD;
                        end
                        else
                        begin
                            blur_done_reg <= 1'b1;
                            estep_reg     <= '0;
                            g1_reg        <= '0;
                            g2_reg        <= '0;
                            border_reg    <= (x_reg == '0) || (y_reg == '0)
                                             || (x_reg == w_eff - WW'(1))
                                             || (y_reg == h_eff - WW'(1));
                            state_reg     <= S_EDGE_RD;
                            if ((x_reg == '0) || (y_reg == '0) || (x_reg == w_eff - WW'(1))
                                || (y_reg == h_eff - WW'(1)))
                                state_reg <= S_OUT;
                        end
                    end
                end
                S_BLUR_RD: state_reg <= S_BLUR_WR;
                S_BLUR_WR:
                begin
                    if (k_reg == '0)
                    begin
                        acc_reg[0] <= {mem_rdata.r, 4'b0000};
                        acc_reg[1] <= {mem_rdata.g, 4'b0000};
                        acc_reg[2] <= {mem_rdata.b, 4'b0000};
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                    state_reg <= S_BLUR_RD;
                    if (k_reg == count - WW'(1))
                    begin
                        k_reg <= '0;
                        if (line_reg == lines - WW'(1))
                        begin
                            line_reg <= '0;
                            pass_reg <= pass_reg + 2'd1;
                            case (pass_reg)
                                2'd0:
                                begin
                                    start_reg <= '0;
                                    addr_reg  <= '0;
                                end
                                2'd1:
                                begin
                                    start_reg <= n_a - w_a;
                                    addr_reg  <= n_a - w_a;
                                end
                                2'd2:
                                begin
                                    start_reg <= w_a - AW'(1);
                                    addr_reg  <= w_a - AW'(1);
                                end
                                default:
                                begin
                                    addr_reg  <= '0;
                                    state_reg <= S_FIN_RD;
                                end
                            endcase
                        end
                        else
                        begin
                            line_reg  <= line_reg + WW'(1);
                            start_reg <= start_reg + line_step;
                            addr_reg  <= start_reg + line_step;
                        end
                    end
                    else
                    begin
                        k_reg    <= k_reg + WW'(1);
                        addr_reg <= elem_back ? (addr_reg - elem_step)
                                              : (addr_reg + elem_step);
                    end
                end
                S_FIN_RD: state_reg <= S_FIN_WR;
                S_FIN_WR:
                begin
                    addr_reg  <= addr_reg + AW'(1);
                    state_reg <= S_FIN_RD;
                    if (addr_reg == n_a - AW'(1))
                    begin
                        blur_done_reg <= 1'b1;
                        estep_reg     <= '0;
                        g1_reg        <= '0;
                        g2_reg        <= '0;
                        border_reg    <= (x_reg == '0) || (y_reg == '0)
                                         || (x_reg == w_eff - WW'(1))
                                         || (y_reg == h_eff - WW'(1));
                        state_reg     <= S_EDGE_RD;
                        if ((x_reg == '0) || (y_reg == '0) || (x_reg == w_eff - WW'(1))
                            || (y_reg == h_eff - WW'(1)))
                            state_reg <= S_OUT;
                    end
                end
                S_EDGE_RD: state_reg <= S_EDGE_WR;
                S_EDGE_WR:
                begin
                    state_reg <= S_EDGE_RD;
                    estep_reg <= estep_reg + 4'd1;
                    if (estep_reg == 4'd0)
                        center_reg <= mem_rdata;
                    else if (estep_reg[0])
                        hold_reg <= mem_rdata;
                    else if (estep_reg == 4'd2 || estep_reg == 4'd4)
                        g1_reg <= g1_reg + 11'(diff_sum);
                    else
                        g2_reg <= g2_reg + 11'(diff_sum);
                    if (estep_reg == 4'd8)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                        if (border_reg || g1_reg > thresh_reg || g2_reg > thresh_reg)
                        begin
                            result_reg.red_out   <= '0;
                            result_reg.green_out <= '0;
                            result_reg.blue_out  <= '0;
                            result_reg.is_edge   <= 1'b1;
                        end
                        else
                        begin
                            result_reg.red_out   <= center_reg.r[7:3];
                            result_reg.green_out <= center_reg.g[7:2];
                            result_reg.blue_out  <= center_reg.b[7:3];
                            result_reg.is_edge   <= 1'b0;
                        end
                        if (read_pos_reg == n_a - AW'(1))
                        begin
                            result_reg.last_pixel <= 1'b1;
                            read_pos_reg          <= '0;
                            x_reg                 <= '0;
                            y_reg                 <= '0;
                            load_pos_reg          <= '0;
                        end
                        else
                        begin
                            result_reg.last_pixel <= 1'b0;
                            read_pos_reg          <= read_pos_reg + AW'(1);
                            if (x_reg == w_eff - WW'(1))
                            begin
                                x_reg <= '0;
                                y_reg <= y_reg + WW'(1);
                            end
                            else
                            begin
                                x_reg <= x_reg + WW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/efb_store.sv @@
module efb_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  efb_pkg::rgb8_t       wdata,
    input  logic [AW-1:0]        raddr,
    output efb_pkg::rgb8_t       rdata
);

    efb_pkg::rgb8_t mem [DEPTH];
    efb_pkg::rgb8_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/efb_alu.sv @@
module efb_alu (
    input  efb_pkg::rgb8_t  px,
    input  efb_pkg::rgb8_t  hold,
    input  efb_pkg::acc_t   acc [3],
    input  logic [3:0]      alpha,
    output efb_pkg::acc_t   acc_next [3],
    output efb_pkg::rgb8_t  blur_px,
    output efb_pkg::rgb8_t  trunc_px,
    output logic [9:0]      diff_sum
);

    logic [7:0]         ch [3];
    logic [7:0]         hc [3];
    logic [7:0]         ad [3];
    logic signed [13:0] diff [3];
    logic signed [18:0] prod [3];
    logic signed [18:0] quo [3];

    assign ch[0] = px.r;
    assign ch[1] = px.g;
    assign ch[2] = px.b;
    assign hc[0] = hold.r;
    assign hc[1] = hold.g;
    assign hc[2] = hold.b;

    // exponential step with division by 16 toward zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = $signed({2'b00, ch[c], 4'b0000}) - $signed({2'b00, acc[c]});
            prod[c] = 19'(diff[c]) * 19'($signed({1'b0, alpha}));
            quo[c] = (prod[c] + (prod[c][18] ? 19'sd15 : 19'sd0)) >>> 4;
            acc_next[c] = acc[c] + quo[c][11:0];
            ad[c] = (ch[c] > hc[c]) ? (ch[c] - hc[c]) : (hc[c] - ch[c]);
        end
    end

    assign blur_px.r = acc_next[0][11:4];
    assign blur_px.g = acc_next[1][11:4];
    assign blur_px.b = acc_next[2][11:4];

    assign trunc_px.r = efb_pkg::exp5(px.r[7:3]);
    assign trunc_px.g = efb_pkg::exp6(px.g[7:2]);
    assign trunc_px.b = efb_pkg::exp5(px.b[7:3]);

    assign diff_sum = 10'(ad[0]) + 10'(ad[1]) + 10'(ad[2]);

endmodule

@@ bench/exp_blur_cartoon_edge_filter_top_tb.sv @@
`timescale 1ns / 1ps

module exp_blur_cartoon_edge_filter_top_tb;

    localparam int FrameMax = 65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = efb_pkg::REG_WIDTH;
    logic [efb_pkg::CfgWidth-1:0] cfg_data = '0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    efb_pkg::pixel_t pixel = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    efb_pkg::result_t result;

    exp_blur_cartoon_edge_filter_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // filter state mirror
    efb_pkg::rgb8_t frame[FrameMax];
    logic [8:0] img_w_reg = 9'd256;
    logic [8:0] img_h_reg = 9'd256;
    logic [7:0] radius_reg = '0;
    logic [10:0] thresh_reg = '0;
    int load_pos = 0;
    int read_pos = 0;
    bit blur_done = 0;
    int loaded_top = 0;

    efb_pkg::result_t pending_pixels[$];
    int mismatches = 0;
    int sent_items = 0;
    bit quiet = 0;
    int stall_hold = 0;
    int stall_pick;

    function automatic int frame_w();
        if (img_w_reg < 1) return 1;
        if (img_w_reg > 256) return 256;
        return img_w_reg;
    endfunction

    function automatic int frame_h();
        if (img_h_reg < 1) return 1;
        if (img_h_reg > 256) return 256;
        return img_h_reg;
    endfunction

    function automatic logic [7:0] widen5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic int chan_of(efb_pkg::rgb8_t p, int c);
        if (c == 0) return p.r;
        if (c == 1) return p.g;
        return p.b;
    endfunction

    function automatic void smooth_line(int idx, int stp, bit back, int cnt, int alpha);
        int acc[3];
        int v16;
        efb_pkg::rgb8_t res;
        for (int c = 0; c < 3; c++) acc[c] = chan_of(frame[idx], c) * 16;
        for (int k = 1; k < cnt; k++)
        begin
            idx = back ? idx - stp : idx + stp;
            for (int c = 0; c < 3; c++)
            begin
                v16 = chan_of(frame[idx], c) * 16;
                acc[c] += ((v16 - acc[c]) * alpha) / 16;
            end
            res.r = 8'((acc[0] >> 4) & 255);
            res.g = 8'((acc[1] >> 4) & 255);
            res.b = 8'((acc[2] >> 4) & 255);
            frame[idx] = res;
        end
    endfunction

    function automatic void smooth_frame();
        int w;
        int h;
        int alpha;
        efb_pkg::rgb8_t p;
        w = frame_w();
        h = frame_h();
        if (radius_reg == 0) return;
        case (radius_reg)
            1: alpha = 14;
            2: alpha = 10;
            3: alpha = 8;
            4: alpha = 6;
            5, 6: alpha = 5;
            7: alpha = 4;
            8, 9, 10, 11: alpha = 3;
            12, 13, 14, 15, 16, 17: alpha = 2;
            default: alpha = 1;
        endcase
        for (int i = 0; i < w; i++) smooth_line(i, w, 0, h, alpha);
        for (int i = 0; i < h; i++) smooth_line(i * w, 1, 0, w, alpha);
        for (int i = 0; i < w; i++) smooth_line((h - 1) * w + i, w, 1, h, alpha);
        for (int i = 0; i < h; i++) smooth_line(i * w + w - 1, 1, 1, w, alpha);
        for (int i = 0; i < w * h; i++)
        begin
            p = frame[i];
            frame[i] = {widen5(p.r[7:3]), widen6(p.g[7:2]), widen5(p.b[7:3])};
        end
    endfunction

    function automatic int grad_sum(int a, int b, int c, int d);
        int s;
        int u;
        int v;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            u = chan_of(frame[a], k) - chan_of(frame[b], k);
            v = chan_of(frame[c], k) - chan_of(frame[d], k);
            s += (u < 0 ? -u : u) + (v < 0 ? -v : v);
        end
        return s;
    endfunction

    function automatic efb_pkg::result_t cartoon_pixel();
        efb_pkg::result_t o;
        int w;
        int h;
        int p;
        int x;
        int y;
        w = frame_w();
        h = frame_h();
        o = '0;
        if (!blur_done)
        begin
            smooth_frame();
            blur_done = 1;
        end
        if (read_pos >= w * h) read_pos = 0;
        p = read_pos;
        y = p / w;
        x = p - y * w;
        if (x == 0 || y == 0 || x == w - 1 || y == h - 1)
            o.is_edge = 1'b1;
        else if (grad_sum(p - 1, p + 1, p - w, p + w) > thresh_reg
                 || grad_sum(p - w - 1, p + w + 1, p - w + 1, p + w - 1) > thresh_reg)
            o.is_edge = 1'b1;
        else
        begin
            o.red_out = frame[p].r[7:3];
            o.green_out = frame[p].g[7:2];
            o.blue_out = frame[p].b[7:3];
        end
        if (p == w * h - 1)
        begin
            o.last_pixel = 1'b1;
            read_pos = 0;
            load_pos = 0;
        end
        else
            read_pos = p + 1;
        return o;
    endfunction

    function automatic void apply_item(efb_pkg::pixel_t it);
        if (it.operation == efb_pkg::OP_LOAD)
        begin
            if (load_pos < frame_w() * frame_h())
            begin
                frame[load_pos] = {widen5(it.red_in), widen6(it.green_in), widen5(it.blue_in)};
                load_pos++;
                if (load_pos > loaded_top) loaded_top = load_pos;
            end
            read_pos = 0;
            blur_done = 0;
        end
        else
            pending_pixels.push_back(cartoon_pixel());
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(efb_pkg::pixel_t it);
        int gap;
        pixel = it;
        pixel_valid = 1'b1;
        do @(posedge clk); while (pixel_stall);
        apply_item(it);
        sent_items++;
        @(negedge clk);
        pixel_valid = 1'b0;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
    endtask

    task automatic load_rgb(logic [4:0] r, logic [5:0] g, logic [4:0] b);
        send_item({efb_pkg::OP_LOAD, r, g, b});
    endtask

    task automatic read_pixels(int k);
        efb_pkg::pixel_t it;
        repeat (k)
        begin
            it = 17'($urandom);
            it.operation = efb_pkg::OP_READ;
            send_item(it);
        end
    endtask

    // random pixels for style 0, else a smooth ramp with noise so some interior pixels pass the edge test
    task automatic load_pixels(int k, int style);
        int base;
        base = $urandom_range(0, 63);
        for (int i = 0; i < k; i++)
        begin
            if (style == 0)
                load_rgb(5'($urandom), 6'($urandom), 5'($urandom));
            else
                load_rgb(5'((base + i + $urandom_range(0, 2)) % 32),
                         6'((base + 2 * i + $urandom_range(0, 3)) % 64),
                         5'((base / 2 + $urandom_range(0, 1)) % 32));
        end
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        drain();
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = 11'(val);
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            efb_pkg::REG_WIDTH, efb_pkg::REG_HEIGHT:
            begin
                if (idx == efb_pkg::REG_WIDTH) img_w_reg = 9'(val);
                else img_h_reg = 9'(val);
                load_pos = 0;
                read_pos = 0;
                blur_done = 0;
            end
            efb_pkg::REG_RADIUS: radius_reg = 8'(val);
            default: thresh_reg = 11'(val);
        endcase
    endtask

    task automatic setup_frame(int w, int h, int rad, int thr);
        write_reg(efb_pkg::REG_WIDTH, w);
        write_reg(efb_pkg::REG_HEIGHT, h);
        write_reg(efb_pkg::REG_RADIUS, rad);
        write_reg(efb_pkg::REG_THRESHOLD, thr);
    endtask

    task automatic test_extreme_pixels();
        setup_frame(4, 4, 0, 2047);
        load_rgb(5'd0, 6'd0, 5'd0);
        load_rgb(5'd31, 6'd63, 5'd31);
        load_rgb(5'd0, 6'd63, 5'd0);
        load_rgb(5'd31, 6'd0, 5'd31);
        repeat (3) load_rgb(5'd31, 6'd63, 5'd31);
        repeat (2) load_rgb(5'd0, 6'd0, 5'd0);
        load_pixels(7, 0);
        load_rgb(5'd21, 6'd42, 5'd10);
        read_pixels(16);
        write_reg(efb_pkg::REG_THRESHOLD, 0);
        read_pixels(16);
    endtask

    task automatic test_tiny_frames();
        setup_frame(0, 2, 1, 2047);
        load_pixels(2, 0);
        load_pixels(2, 0);
        read_pixels(2);
        setup_frame(2, 1, 17, 2047);
        load_pixels(2, 1);
        read_pixels(2);
    endtask

    task automatic test_reblur_and_reread();
        setup_frame(3, 3, 1, 2047);
        load_pixels(9, 1);
        read_pixels(9);
        read_pixels(9);
        read_pixels(4);
        load_pixels(2, 0);
        read_pixels(9);
        write_reg(efb_pkg::REG_RADIUS, 18);
        load_pixels(1, 1);
        read_pixels(9);
    endtask

    task automatic test_extreme_geometry();
        setup_frame(511, 3, 255, 40);
        load_pixels(768, 1);
        read_pixels(300);
        setup_frame(1, 300, 3, 2047);
        load_pixels(256, 1);
        read_pixels(100);
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        int n;
        int r;
        int rad;
        int thr;
        while (sent_items < 1700)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            r = $urandom_range(0, 9);
            rad = r < 2 ? 0 : (r < 8 ? $urandom_range(1, 17) : $urandom_range(18, 255));
            r = $urandom_range(0, 9);
            thr = r == 0 ? 0 : (r == 1 ? 2047 : $urandom_range(0, 300));
            setup_frame(w, h, rad, thr);
            n = frame_w() * frame_h();
            load_pixels(n, $urandom_range(0, 2) == 0 ? 0 : 1);
            r = $urandom_range(0, 9);
            if (r == 0)
                load_pixels($urandom_range(1, 3), 0);
            if (r < 3)
            begin
                read_pixels($urandom_range(0, n - 1));
                load_pixels($urandom_range(0, n - 1), 0);
            end
            read_pixels(n);
            if (r == 4)
            begin
                write_reg(efb_pkg::REG_THRESHOLD, $urandom_range(0, 2047));
                read_pixels(n);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (quiet || stall_pick < 65)
                result_stall <= 1'b0;
            else
            begin
                result_stall <= 1'b1;
                stall_hold <= stall_pick < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", result);
            end
            else if (result !== pending_pixels[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p actual %p",
                             pending_pixels[0], result);
                void'(pending_pixels.pop_front());
            end
            else
                void'(pending_pixels.pop_front());
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extreme_pixels();
        test_tiny_frames();
        test_reblur_and_reread();
        test_extreme_geometry();
        test_random_frames();
        drain();
        if (mismatches == 0)
            $display("PASS exp_blur_cartoon_edge_filter_top");
        else
            $display("FAIL exp_blur_cartoon_edge_filter_top");
        $finish;
    end

    initial
    begin
        #12ms;
        $display("FAIL exp_blur_cartoon_edge_filter_top");
        $finish;
    end

endmodule

@@ filelist.f @@
src/efb_pkg.sv
src/efb_store.sv
src/efb_alu.sv
src/exp_blur_cartoon_edge_filter_top.sv
bench/exp_blur_cartoon_edge_filter_top_tb.sv
